### rtl/core/rbah_pkg.sv
// shared types, constants and constant functions for the rotated box and arc hit test
// no dependencies; imported by rbah_cordic_cell and rotated_box_and_arc_hit_test
`default_nettype none

package rbah_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_COUNT    = 24;
   localparam int STAGE_IDX_W   = $clog2(ATAN_COUNT);
   localparam int FRAC_BITS     = 25;
   localparam int XW            = 64;
   localparam int ZW            = 34;
   localparam int EW            = 33 + FRAC_BITS;
   localparam int SW            = 31;

   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   typedef enum logic [1:0] {
      MODE_BOX        = 2'd0,
      MODE_ARC_CENTER = 2'd1,
      MODE_ARC_MID    = 2'd2,
      MODE_NONE       = 2'd3
   } mode_type;

   localparam logic [31:0] ATAN_TABLE [0:ATAN_COUNT-1] = '{
      32'd536870912, 32'd316933406, 32'd167458908, 32'd85004757, 32'd42667332,
      32'd21354466, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
   };

   // side data that travels with an item along both cordic chains
   typedef struct packed {
      mode_type              mode;
      logic signed [EW-1:0]  ex;
      logic signed [EW-1:0]  ey;
      logic [SW-1:0]         w;
      logic [SW-1:0]         h;
      logic signed [33:0]    lo2;
      logic signed [33:0]    hi2;
      logic [31:0]           a32;
      logic [31:0]           d32;
      logic                  hit_box;
      logic                  rad_ok;
      logic                  ang_zero;
   } side_type;

   typedef struct packed {
      logic                  valid;
      logic signed [XW-1:0]  x;
      logic signed [XW-1:0]  y;
      logic signed [ZW-1:0]  z;
      side_type              tag;
   } cell_data_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // cordic gain in q30
   function automatic logic [63:0] gain_q30();
      logic [63:0] k2;
      k2 = 64'd1 << 60;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         k2 = k2 + (k2 >> (2 * i));
      end
      return isqrt64(k2);
   endfunction

   localparam logic [63:0] K_GAIN = gain_q30();
   localparam logic [63:0] INV_K  = (64'd1 << 61) / K_GAIN;

endpackage

`default_nettype wire

### rtl/core/rotated_box_and_arc_hit_test.sv
// top level of the rotated box and arc hit test: input stage, two cordic chains,
// squared radius compare and output skid; depends on rbah_pkg and rbah_cordic_cell
`default_nettype none

// One pick shape and one query point go in per beat, one hit bit comes out per
// beat, in order. A new beat is taken every cycle while the output skid is empty.
// An accepted beat passes the input and setup registers, two chains of 16 cordic
// cells (rotation, then vectoring) with the partial product and compare registers
// between them, then the result register. Mode 0 rotates the offset into the box
// frame and checks both half extents; mode 1 uses the given arc center, mode 2
// first derives the center from the arc midpoint through the rotation chain;
// mode 3 always misses. The radius is checked exactly as squares, the angle
// through the vectoring chain. A two-entry output (output register plus skid)
// keeps req_tready free of any combinational path from rsp_tready. Not enforced:
// the user writes expand_margin through csr_wr_en / csr_wr_data while idle.
module rotated_box_and_arc_hit_test import rbah_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [30:0]   csr_wr_data,  // expand_margin
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // point_x[31:0] point_y[63:32] ref_x[95:64] ref_y[127:96] size_a[158:128]
   // size_b[189:159] angle_a[205:190] angle_b[221:206], zero pad
   input  wire logic [223:0]  req_tdata,
   input  wire logic [1:0]    req_tuser,    // mode
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [7:0]         rsp_tdata     // hit[0], zero pad
);

   localparam int N = CORDIC_STAGES;

   // pipeline moves as a whole while the skid is empty
   logic en;

   logic [SW-1:0] margin_ff;

   // input register
   logic               s0_v_ff;
   mode_type           s0_mode_ff;
   logic signed [31:0] s0_px_ff, s0_py_ff, s0_rx_ff, s0_ry_ff;
   logic [SW-1:0]      s0_sa_ff, s0_sb_ff;
   logic [15:0]        s0_aa_ff, s0_ab_ff;

   // setup stage
   logic               s1_v_ff;
   side_type           s1_side_ff, s1_side_in;
   logic [63:0]        s1_prod_ff, s1_prod_in;
   logic [31:0]        s1_theta_ff, s1_theta_in;

   // cordic chains
   cell_data_type      ca [0:N];
   cell_data_type      cb [0:N];

   // after rotation chain
   logic                 q1_v_ff, q2_v_ff, q3_v_ff, q4_v_ff, q5_v_ff, q6_v_ff;
   side_type             q1_side_ff, q2_side_ff, q3_side_ff, q4_side_ff, q5_side_ff;
   side_type             q6_side_ff;
   side_type             q1_side_in, q2_side_in, q6_side_in;
   logic signed [XW-1:0] q1_x_ff, q1_y_ff, q1_x_in, q1_y_in;
   logic [61:0]          q1_wk_ff, q1_hk_ff, q1_wk_in, q1_hk_in;
   logic signed [XW-1:0] q2_x_ff, q2_y_ff, q3_x_ff, q3_y_ff, q4_x_ff, q4_y_ff;
   logic signed [XW-1:0] q5_x_ff, q5_y_ff, q6_x_ff, q6_y_ff;
   logic [XW-1:0]        q2_ax_ff, q2_ay_ff, q2_ax_in, q2_ay_in;
   logic [63:0]          q3_x00_ff, q3_x01_ff, q3_x11_ff;
   logic [63:0]          q3_y00_ff, q3_y01_ff, q3_y11_ff;
   logic [63:0]          q3_l0_ff, q3_h0_ff;
   logic [127:0]         q4_sqx_ff, q4_sqy_ff, q4_sqx_in, q4_sqy_in;
   logic [66:0]          q4_lsq_ff, q4_hsq_ff, q4_lsq_in, q4_hsq_in;
   logic [127:0]         q5_sum_ff;
   logic [66:0]          q5_lsq_ff, q5_hsq_ff;

   // result stage and output
   logic r_v_ff, r_hit_ff, r_hit_in;
   logic out_v_ff, out_v_in, out_hit_ff, out_hit_in;
   logic skid_v_ff, skid_v_in, skid_hit_ff, skid_hit_in;
   logic take;

   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'b0, out_hit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else if (csr_wr_en) begin
         margin_ff <= csr_wr_data;
      end
   end

   // valid bits for the plain stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         q1_v_ff <= 1'b0;
         q2_v_ff <= 1'b0;
         q3_v_ff <= 1'b0;
         q4_v_ff <= 1'b0;
         q5_v_ff <= 1'b0;
         q6_v_ff <= 1'b0;
         r_v_ff  <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_tvalid;
         s1_v_ff <= s0_v_ff;
         q1_v_ff <= ca[N].valid;
         q2_v_ff <= q1_v_ff;
         q3_v_ff <= q2_v_ff;
         q4_v_ff <= q3_v_ff;
         q5_v_ff <= q4_v_ff;
         q6_v_ff <= q5_v_ff;
         r_v_ff  <= cb[N].valid;
      end
   end

   // capture the beat
   always_ff @(posedge clock) begin
      if (en) begin
         s0_mode_ff <= mode_type'(req_tuser);
         s0_px_ff   <= req_tdata[31:0];
         s0_py_ff   <= req_tdata[63:32];
         s0_rx_ff   <= req_tdata[95:64];
         s0_ry_ff   <= req_tdata[127:96];
         s0_sa_ff   <= req_tdata[158:128];
         s0_sb_ff   <= req_tdata[189:159];
         s0_aa_ff   <= req_tdata[205:190];
         s0_ab_ff   <= req_tdata[221:206];
      end
   end

   // setup: scaled offset, padded sizes, radius band, midpoint vector length
   logic signed [32:0] off_x, off_y, diff, ext, mg_s;
   logic [31:0]        sum;

   always_comb begin
      off_x = 33'(s0_px_ff) - 33'(s0_rx_ff);
      off_y = 33'(s0_py_ff) - 33'(s0_ry_ff);
      sum   = {1'b0, s0_sa_ff} + {1'b0, s0_sb_ff};
      diff  = $signed({2'b00, s0_sb_ff}) - $signed({2'b00, s0_sa_ff});
      mg_s  = $signed({2'b00, margin_ff});
      ext   = (diff > mg_s) ? diff : mg_s;

      s1_side_in          = '0;
      s1_side_in.mode     = s0_mode_ff;
      s1_side_in.ex       = {off_x, {FRAC_BITS{1'b0}}};
      s1_side_in.ey       = {off_y, {FRAC_BITS{1'b0}}};
      s1_side_in.w        = (s0_sa_ff > margin_ff) ? s0_sa_ff : margin_ff;
      s1_side_in.h        = (s0_sb_ff > margin_ff) ? s0_sb_ff : margin_ff;
      s1_side_in.lo2      = $signed({2'b00, sum}) - 34'(ext);
      s1_side_in.hi2      = $signed({2'b00, sum}) + 34'(ext);
      s1_side_in.a32      = {s0_aa_ff, 16'h0000};
      s1_side_in.d32      = {s0_ab_ff, 16'h0000};

      // half the band middle, divided by the gain, in the scaled grid
      s1_prod_in = sum * INV_K[31:0];

      if (s0_mode_ff == MODE_BOX) begin
         s1_theta_in = 32'd0 - s1_side_in.a32;
      end else begin
         s1_theta_in = s1_side_in.a32 + {1'b0, s1_side_in.d32[31:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_side_ff  <= s1_side_in;
         s1_prod_ff  <= s1_prod_in;
         s1_theta_ff <= s1_theta_in;
      end
   end

   // rotation pre-step: fold the angle into the right half plane
   logic signed [XW-1:0] pa_x, pa_y;
   logic [31:0]          th_chk, th;

   always_comb begin
      unique case (s1_side_ff.mode)
         MODE_BOX: begin
            pa_x = XW'(s1_side_ff.ex);
            pa_y = XW'(s1_side_ff.ey);
         end
         MODE_ARC_MID: begin
            pa_x = $signed({7'b0, s1_prod_ff[63:7]});
            pa_y = '0;
         end
         MODE_ARC_CENTER, MODE_NONE: begin
            pa_x = '0;
            pa_y = '0;
         end
      endcase
      th_chk = s1_theta_ff + QUARTER_TURN;
      th     = s1_theta_ff;
      if (th_chk[31]) begin
         pa_x = -pa_x;
         pa_y = -pa_y;
         th   = s1_theta_ff + HALF_TURN;
      end
      ca[0].valid = s1_v_ff;
      ca[0].x     = pa_x;
      ca[0].y     = pa_y;
      ca[0].z     = ZW'($signed(th));
      ca[0].tag   = s1_side_ff;
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      rbah_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (en),
         .vectoring (1'b0),
         .stage_idx (STAGE_IDX_W'(i)),
         .din       (ca[i]),
         .dout      (ca[i+1])
      );
   end

   // q1: arc offset from the center, or rotated box offset; scaled extents
   always_comb begin
      q1_side_in = ca[N].tag;
      unique case (ca[N].tag.mode)
         MODE_BOX: begin
            q1_x_in = ca[N].x;
            q1_y_in = ca[N].y;
         end
         MODE_ARC_MID: begin
            q1_x_in = XW'(ca[N].tag.ex) + ca[N].x;
            q1_y_in = XW'(ca[N].tag.ey) + ca[N].y;
         end
         MODE_ARC_CENTER, MODE_NONE: begin
            q1_x_in = XW'(ca[N].tag.ex);
            q1_y_in = XW'(ca[N].tag.ey);
         end
      endcase
      q1_wk_in = ca[N].tag.w * K_GAIN[30:0];
      q1_hk_in = ca[N].tag.h * K_GAIN[30:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_side_ff <= q1_side_in;
         q1_x_ff    <= q1_x_in;
         q1_y_ff    <= q1_y_in;
         q1_wk_ff   <= q1_wk_in;
         q1_hk_ff   <= q1_hk_in;
      end
   end

   // q2: magnitudes and the inclusive box test
   always_comb begin
      q2_ax_in = q1_x_ff[XW-1] ? XW'(-q1_x_ff) : XW'(q1_x_ff);
      q2_ay_in = q1_y_ff[XW-1] ? XW'(-q1_y_ff) : XW'(q1_y_ff);
      q2_side_in         = q1_side_ff;
      q2_side_in.hit_box = ({q2_ax_in, 6'b0} <= 70'(q1_wk_ff))
                        && ({q2_ay_in, 6'b0} <= 70'(q1_hk_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q2_side_ff <= q2_side_in;
         q2_ax_ff   <= q2_ax_in;
         q2_ay_ff   <= q2_ay_in;
         q2_x_ff    <= q1_x_ff;
         q2_y_ff    <= q1_y_ff;
      end
   end

   // q3: 32x32 partial products of the squares
   always_ff @(posedge clock) begin
      if (en) begin
         q3_side_ff <= q2_side_ff;
         q3_x_ff    <= q2_x_ff;
         q3_y_ff    <= q2_y_ff;
         q3_x00_ff  <= q2_ax_ff[31:0] * q2_ax_ff[31:0];
         q3_x01_ff  <= q2_ax_ff[31:0] * q2_ax_ff[63:32];
         q3_x11_ff  <= q2_ax_ff[63:32] * q2_ax_ff[63:32];
         q3_y00_ff  <= q2_ay_ff[31:0] * q2_ay_ff[31:0];
         q3_y01_ff  <= q2_ay_ff[31:0] * q2_ay_ff[63:32];
         q3_y11_ff  <= q2_ay_ff[63:32] * q2_ay_ff[63:32];
         q3_l0_ff   <= q2_side_ff.lo2[31:0] * q2_side_ff.lo2[31:0];
         q3_h0_ff   <= q2_side_ff.hi2[31:0] * q2_side_ff.hi2[31:0];
      end
   end

   // q4: per-axis squares and band edge squares (bit 32 folded in)
   always_comb begin
      q4_sqx_in = {q3_x11_ff, 64'b0} + {31'b0, q3_x01_ff, 33'b0} + {64'b0, q3_x00_ff};
      q4_sqy_in = {q3_y11_ff, 64'b0} + {31'b0, q3_y01_ff, 33'b0} + {64'b0, q3_y00_ff};
      q4_lsq_in = 67'(q3_l0_ff);
      if (q3_side_ff.lo2[32]) begin
         q4_lsq_in = q4_lsq_in + 67'({q3_side_ff.lo2[31:0], 33'b0}) + (67'd1 << 64);
      end
      q4_hsq_in = 67'(q3_h0_ff);
      if (q3_side_ff.hi2[32]) begin
         q4_hsq_in = q4_hsq_in + 67'({q3_side_ff.hi2[31:0], 33'b0}) + (67'd1 << 64);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q4_side_ff <= q3_side_ff;
         q4_x_ff    <= q3_x_ff;
         q4_y_ff    <= q3_y_ff;
         q4_sqx_ff  <= q4_sqx_in;
         q4_sqy_ff  <= q4_sqy_in;
         q4_lsq_ff  <= q4_lsq_in;
         q4_hsq_ff  <= q4_hsq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q5_side_ff <= q4_side_ff;
         q5_x_ff    <= q4_x_ff;
         q5_y_ff    <= q4_y_ff;
         q5_sum_ff  <= q4_sqx_ff + q4_sqy_ff;
         q5_lsq_ff  <= q4_lsq_ff;
         q5_hsq_ff  <= q4_hsq_ff;
      end
   end

   // q6: radius strictly inside the band
   always_comb begin
      q6_side_in        = q5_side_ff;
      q6_side_in.rad_ok = (q5_side_ff.lo2[33] || (q5_sum_ff > 128'({q5_lsq_ff, 48'b0})))
                       && (q5_sum_ff < 128'({q5_hsq_ff, 48'b0}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q6_side_ff <= q6_side_in;
         q6_x_ff    <= q5_x_ff;
         q6_y_ff    <= q5_y_ff;
      end
   end

   // vectoring pre-step: left half plane starts from a half turn
   always_comb begin
      cb[0].valid        = q6_v_ff;
      cb[0].tag          = q6_side_ff;
      cb[0].tag.ang_zero = (q6_x_ff == '0) && (q6_y_ff == '0);
      if (q6_x_ff[XW-1]) begin
         cb[0].x = -q6_x_ff;
         cb[0].y = -q6_y_ff;
         cb[0].z = $signed({2'b00, HALF_TURN});
      end else begin
         cb[0].x = q6_x_ff;
         cb[0].y = q6_y_ff;
         cb[0].z = '0;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_vec
      rbah_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (en),
         .vectoring (1'b1),
         .stage_idx (STAGE_IDX_W'(i)),
         .din       (cb[i]),
         .dout      (cb[i+1])
      );
   end

   // final decision
   logic [31:0] ang;
   logic [31:0] ang_rel;
   logic        arc_hit;

   always_comb begin
      ang     = cb[N].tag.ang_zero ? 32'd0 : cb[N].z[31:0];
      ang_rel = ang - cb[N].tag.a32;
      arc_hit = cb[N].tag.rad_ok && (ang_rel < cb[N].tag.d32);
      unique case (cb[N].tag.mode)
         MODE_BOX:                      r_hit_in = cb[N].tag.hit_box;
         MODE_ARC_CENTER, MODE_ARC_MID: r_hit_in = arc_hit;
         MODE_NONE:                     r_hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_hit_ff <= r_hit_in;
      end
   end

   // output register with skid
   always_comb begin
      take        = out_v_ff && rsp_tready;
      out_v_in    = out_v_ff;
      out_hit_in  = out_hit_ff;
      skid_v_in   = skid_v_ff;
      skid_hit_in = skid_hit_ff;
      if (skid_v_ff) begin
         if (take) begin
            out_v_in   = 1'b1;
            out_hit_in = skid_hit_ff;
            skid_v_in  = 1'b0;
         end
      end else if (!out_v_ff || take) begin
         out_v_in   = r_v_ff;
         out_hit_in = r_hit_ff;
      end else if (r_v_ff) begin
         skid_v_in   = 1'b1;
         skid_hit_in = r_hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_hit_ff  <= out_hit_in;
      skid_hit_ff <= skid_hit_in;
   end

   // skid only ever holds a beat behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds a beat while the output register is empty");

   // a finished result that meets a stalled output lands in the skid
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (r_v_ff && en && out_v_ff && !rsp_tready) |=> skid_v_ff)
      else $error("result dropped at a stalled output");

   // a taken beat with the skid full moves the skid forward
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_tready) |=> (out_v_ff && !skid_v_ff))
      else $error("skid did not drain into the output register");

endmodule

`default_nettype wire

### rtl/core/rbah_cordic_cell.sv
// one cordic micro-rotation cell, registered, for rotation or vectoring
// depends on rbah_pkg (cell_data_type, ATAN_TABLE)
`default_nettype none

module rbah_cordic_cell import rbah_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    vectoring,
   input  wire logic [STAGE_IDX_W-1:0]  stage_idx,
   input  wire cell_data_type           din,
   output cell_data_type                dout
);

   logic                 valid_ff;
   logic                 valid_in;
   cell_data_type        data_ff;
   cell_data_type        data_in;
   logic signed [XW-1:0] sx;
   logic signed [XW-1:0] sy;
   logic signed [ZW-1:0] atan_step;
   logic                 turn_neg;

   always_comb begin
      sx        = din.y >>> stage_idx;
      sy        = din.x >>> stage_idx;
      atan_step = $signed({2'b00, ATAN_TABLE[stage_idx]});
      // vectoring drives y toward zero, rotation drives z toward zero
      turn_neg  = vectoring ? din.y[XW-1] : !din.z[ZW-1];
      data_in   = din;
      if (turn_neg) begin
         data_in.x = din.x - sx;
         data_in.y = din.y + sy;
         data_in.z = din.z - atan_step;
      end else begin
         data_in.x = din.x + sx;
         data_in.y = din.y - sy;
         data_in.z = din.z + atan_step;
      end
      valid_in = advance ? din.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      dout       = data_ff;
      dout.valid = valid_ff;
   end

endmodule

`default_nettype wire
